// ===== rtl/smtrs_pkg.sv =====
package smtrs_pkg;

  localparam int FRAME_DEPTH = 2;
  localparam int OUT_DEPTH   = 4;

  // Configuration register indexes.
  localparam logic [2:0] REG_TILE_SHIFT = 3'd0;
  localparam logic [2:0] REG_MAP_WIDTH  = 3'd1;
  localparam logic [2:0] REG_MAP_HEIGHT = 3'd2;
  localparam logic [2:0] REG_VIEW_WIDTH = 3'd3;
  localparam logic [2:0] REG_VIEW_HEIGHT = 3'd4;
  localparam logic [2:0] REG_BUF_HEIGHT = 3'd5;
  localparam logic [2:0] REG_COL_RUN    = 3'd6;
  localparam logic [2:0] REG_ROW_RUN    = 3'd7;

  localparam logic [4:0]  RUN_MAX     = 5'd29;
  localparam logic [15:0] RUN_BACKOFF = 16'd2;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  typedef struct packed {
    logic [2:0]  tile_shift;
    logic [11:0] map_width_tiles;
    logic [11:0] map_height_tiles;
    logic [9:0]  view_width;
    logic [9:0]  view_height;
    logic [10:0] buffer_height;
    logic [4:0]  column_run_length;
    logic [4:0]  row_run_length;
  } cfg_t;

  // One axis of a frame, already classified by the front end.
  typedef struct packed {
    logic        moving;
    logic        forward;
    logic [15:0] idx;
    logic [15:0] run_next;
    logic [15:0] run_end;
  } axis_cmd_t;

  typedef struct packed {
    axis_cmd_t [1:0] axis;
  } frame_t;

  typedef struct packed {
    logic [11:0] tile_x;
    logic [11:0] tile_y;
    logic [15:0] buffer_x;
    logic [9:0]  buffer_y;
    logic        last;
  } draw_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AXIS,
    ST_LOAD,
    ST_FLUSH,
    ST_OPP,
    ST_PEND,
    ST_END
  } state_t;

endpackage

// ===== rtl/smtrs_fifo.sv =====
module smtrs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/smtrs_front.sv =====
module smtrs_front (
  input  smtrs_pkg::cfg_t   cfg,
  input  logic [15:0]       camera_x,
  input  logic [15:0]       camera_y,
  input  logic signed [15:0] delta_x,
  input  logic signed [15:0] delta_y,
  output smtrs_pkg::frame_t frame
);
  import smtrs_pkg::*;

  // Works out the target tile index and the bounds of a new run for one axis.
  function automatic axis_cmd_t classify(
    input logic [15:0] cam_lead,
    input logic [15:0] cam_run,
    input logic [15:0] delta,
    input logic [9:0]  view,
    input logic [11:0] lead_bound,
    input logic [11:0] run_bound,
    input logic [4:0]  run_len,
    input logic [2:0]  sh
  );
    logic [16:0] sum;
    logic [15:0] sum_tiles;
    logic [15:0] idx;
    logic [15:0] run_tiles;
    logic [15:0] first;
    logic [16:0] stop;
    logic [4:0]  rl;
    axis_cmd_t   cmd;
    sum       = {1'b0, cam_lead} + {7'b0, view};
    sum_tiles = 16'(sum >> sh);
    if (!delta[15]) begin
      idx = sum_tiles + 16'd1;
    end else begin
      idx = (cam_lead >> sh) - 16'd1;
    end
    run_tiles = cam_run >> sh;
    first     = (run_tiles >= RUN_BACKOFF) ? run_tiles - RUN_BACKOFF : '0;
    rl        = (run_len > RUN_MAX) ? RUN_MAX : run_len;
    stop      = {1'b0, first} + {12'b0, rl};
    cmd.moving  = |delta;
    cmd.forward = !delta[15];
    cmd.idx     = idx;
    // A target beyond the map, or one that wrapped negative, opens an empty run.
    if (idx[15] || (idx >= {4'b0, lead_bound})) begin
      cmd.run_next = '0;
      cmd.run_end  = '0;
    end else begin
      cmd.run_next = first;
      cmd.run_end  = (stop > {5'b0, run_bound}) ? {4'b0, run_bound} : stop[15:0];
    end
    return cmd;
  endfunction

  always_comb begin
    frame.axis[AXIS_X] = classify(camera_x, camera_y, delta_x, cfg.view_width,
                                  cfg.map_width_tiles, cfg.map_height_tiles,
                                  cfg.column_run_length, cfg.tile_shift);
    frame.axis[AXIS_Y] = classify(camera_y, camera_x, delta_y, cfg.view_height,
                                  cfg.map_height_tiles, cfg.map_width_tiles,
                                  cfg.row_run_length, cfg.tile_shift);
  end

endmodule

// ===== rtl/smtrs_back.sv =====
module smtrs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  smtrs_pkg::cfg_t   cfg,
  input  logic              fq_empty,
  input  smtrs_pkg::frame_t fq_data,
  output logic              fq_pop,
  input  logic              oq_full,
  output logic              oq_push,
  output smtrs_pkg::draw_t  oq_data
);
  import smtrs_pkg::*;

  state_t       state_r, state_nxt;
  frame_t       frame_r, frame_nxt;
  logic         bank_r, bank_nxt;
  logic         ax_r, ax_nxt;
  logic         side_r, side_nxt;
  logic         moved_r, moved_nxt;
  logic [1:0][1:0] lead_r, lead_nxt;
  logic [15:0]  w_pos_r, w_pos_nxt;
  logic [15:0]  w_next_r, w_next_nxt;
  logic [15:0]  w_end_r, w_end_nxt;
  draw_t        hold_r, hold_nxt;
  logic         hold_v_r, hold_v_nxt;

  // Margin state: entry {bank, axis, trailing side}.
  logic [15:0]  pos_r  [8];
  logic [15:0]  next_r [8];
  logic [15:0]  end_r  [8];

  logic         wr_en;
  logic [2:0]   wr_idx;
  logic [15:0]  wr_pos, wr_next, wr_end;

  axis_cmd_t    cur;
  logic [2:0]   m_idx, opp_idx, rd_idx;
  logic [15:0]  rd_pos;
  logic         pending;
  logic         can_emit;
  logic         emit;
  logic         retarget;
  logic [15:0]  tx, ty;
  logic [15:0]  ty_shift;
  logic [10:0]  wrap_mask;

  assign cur      = frame_r.axis[ax_r];
  assign m_idx    = {bank_r, ax_r, ~side_r};
  assign opp_idx  = {bank_r, ax_r, side_r};
  assign rd_idx   = (state_r == ST_OPP) ? opp_idx : m_idx;
  assign rd_pos   = pos_r[rd_idx];
  assign pending  = $signed(w_next_r) < $signed(w_end_r);
  assign can_emit = !hold_v_r || !oq_full;
  assign retarget = moved_r && (cur.idx != rd_pos);

  // The word being built: the run coordinate goes to the other axis.
  assign tx        = (ax_r == AXIS_X) ? w_pos_r : w_next_r;
  assign ty        = (ax_r == AXIS_X) ? w_next_r : w_pos_r;
  assign ty_shift  = ty << cfg.tile_shift;
  assign wrap_mask = cfg.buffer_height - 11'd1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!fq_empty) begin
          state_nxt = ST_AXIS;
        end
      end
      ST_AXIS: state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = retarget ? ST_FLUSH : ST_PEND;
      ST_FLUSH: begin
        if (!pending) begin
          state_nxt = ST_OPP;
        end
      end
      ST_OPP: state_nxt = ST_PEND;
      ST_PEND: begin
        if (!pending || can_emit) begin
          state_nxt = (ax_r == AXIS_X) ? ST_AXIS : ST_END;
        end
      end
      ST_END: begin
        if (!hold_v_r || !oq_full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    frame_nxt  = frame_r;
    bank_nxt   = bank_r;
    ax_nxt     = ax_r;
    side_nxt   = side_r;
    moved_nxt  = moved_r;
    lead_nxt   = lead_r;
    w_pos_nxt  = w_pos_r;
    w_next_nxt = w_next_r;
    w_end_nxt  = w_end_r;
    hold_v_nxt = hold_v_r;
    fq_pop     = 1'b0;
    emit       = 1'b0;
    wr_en      = 1'b0;
    wr_idx     = m_idx;
    wr_pos     = w_pos_r;
    wr_next    = w_next_r;
    wr_end     = w_end_r;
    oq_push    = 1'b0;
    oq_data    = hold_r;
    oq_data.last = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!fq_empty) begin
          fq_pop    = 1'b1;
          frame_nxt = fq_data;
          ax_nxt    = AXIS_X;
        end
      end
      ST_AXIS: begin
        moved_nxt = cur.moving;
        if (cur.moving) begin
          lead_nxt[bank_r][ax_r] = cur.forward;
          side_nxt = cur.forward;
        end else begin
          side_nxt = lead_r[bank_r][ax_r];
        end
      end
      ST_LOAD: begin
        w_pos_nxt  = pos_r[m_idx];
        w_next_nxt = next_r[m_idx];
        w_end_nxt  = end_r[m_idx];
      end
      ST_FLUSH: begin
        if (pending) begin
          if (can_emit) begin
            emit       = 1'b1;
            w_next_nxt = w_next_r + 16'd1;
          end
        end else begin
          wr_en      = 1'b1;
          wr_pos     = cur.idx;
          wr_next    = cur.run_next;
          wr_end     = cur.run_end;
          w_pos_nxt  = cur.idx;
          w_next_nxt = cur.run_next;
          w_end_nxt  = cur.run_end;
        end
      end
      ST_OPP: begin
        wr_en   = 1'b1;
        wr_idx  = opp_idx;
        wr_pos  = cur.forward ? rd_pos + 16'd1 : rd_pos - 16'd1;
        wr_next = '0;
        wr_end  = '0;
      end
      ST_PEND: begin
        if (pending && can_emit) begin
          emit       = 1'b1;
          w_next_nxt = w_next_r + 16'd1;
          wr_en      = 1'b1;
          wr_next    = w_next_r + 16'd1;
        end
        if (!pending || can_emit) begin
          ax_nxt = AXIS_Y;
        end
      end
      ST_END: begin
        if (!hold_v_r || !oq_full) begin
          oq_push      = hold_v_r;
          oq_data.last = 1'b1;
          hold_v_nxt   = 1'b0;
          bank_nxt     = ~bank_r;
        end
      end
      default: ;
    endcase
    // The newest word waits in the hold register until the next one shows
    // whether it closes the frame.
    if (emit) begin
      oq_push    = hold_v_r;
      hold_v_nxt = 1'b1;
    end
  end

  always_comb begin
    hold_nxt = hold_r;
    if (emit) begin
      hold_nxt.tile_x   = tx[11:0];
      hold_nxt.tile_y   = ty[11:0];
      hold_nxt.buffer_x = tx << cfg.tile_shift;
      hold_nxt.buffer_y = ty_shift[9:0] & wrap_mask[9:0];
      hold_nxt.last     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      bank_r   <= 1'b0;
      ax_r     <= AXIS_X;
      side_r   <= 1'b1;
      moved_r  <= 1'b0;
      lead_r   <= '1;
      hold_v_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        pos_r[i]  <= '0;
        next_r[i] <= '0;
        end_r[i]  <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      bank_r   <= bank_nxt;
      ax_r     <= ax_nxt;
      side_r   <= side_nxt;
      moved_r  <= moved_nxt;
      lead_r   <= lead_nxt;
      hold_v_r <= hold_v_nxt;
      if (wr_en) begin
        pos_r[wr_idx]  <= wr_pos;
        next_r[wr_idx] <= wr_next;
        end_r[wr_idx]  <= wr_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    frame_r  <= frame_nxt;
    w_pos_r  <= w_pos_nxt;
    w_next_r <= w_next_nxt;
    w_end_r  <= w_end_nxt;
    hold_r   <= hold_nxt;
  end

endmodule

// ===== rtl/scroll_margin_tile_redraw_scheduler_unit.sv =====
// Scroll-margin tile redraw scheduler.
// Input: one word per video frame (camera position and motion on each axis),
// written with push while full is low. Results: tile draw commands, read like
// a queue; a command is on the out_ ports while empty is low and is taken with
// pop. The last command of a frame carries out_last; a frame may give none.
// Configuration is written through cfg_we/cfg_index/cfg_wdata between frames.
// A frame goes through a small frame queue to the back-end sequencer, which
// works the x axis and then the y axis. An axis whose margin moves also goes
// through a flush step, which draws out the rest of the old run word by word,
// and an update of the opposite margin. One word is held back until it is
// known whether it ends the frame.
// Frames arriving while the sequencer is busy wait in the frame queue; full
// rises when it fills. When pop stays low the result queue fills and the
// sequencer waits; nothing is dropped.
// Reset is synchronous: margin state is cleared, both leading sides point
// right and down, bank 0 is active, and the registers return to their
// defaults (16-pixel tiles, 64 x 64 map, 320 x 256 view, 512-line buffer).
module scroll_margin_tile_redraw_scheduler_unit #(
  parameter int FRAME_DEPTH = smtrs_pkg::FRAME_DEPTH,
  parameter int OUT_DEPTH   = smtrs_pkg::OUT_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [11:0]        cfg_wdata,
  input  logic               push,
  output logic               full,
  input  logic [15:0]        in_camera_x,
  input  logic [15:0]        in_camera_y,
  input  logic signed [15:0] in_delta_x,
  input  logic signed [15:0] in_delta_y,
  output logic               empty,
  input  logic               pop,
  output logic [11:0]        out_tile_x,
  output logic [11:0]        out_tile_y,
  output logic [15:0]        out_buffer_x,
  output logic [9:0]         out_buffer_y,
  output logic               out_last
);
  import smtrs_pkg::*;

  cfg_t   cfg_r;
  frame_t front_frame;
  frame_t fq_data;
  logic   fq_empty, fq_pop;
  logic   oq_full, oq_push;
  draw_t  oq_wdata, oq_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tile_shift        <= 3'd4;
      cfg_r.map_width_tiles   <= 12'd64;
      cfg_r.map_height_tiles  <= 12'd64;
      cfg_r.view_width        <= 10'd320;
      cfg_r.view_height       <= 10'd256;
      cfg_r.buffer_height     <= 11'd512;
      cfg_r.column_run_length <= 5'd20;
      cfg_r.row_run_length    <= 5'd24;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TILE_SHIFT:  cfg_r.tile_shift        <= cfg_wdata[2:0];
        REG_MAP_WIDTH:   cfg_r.map_width_tiles   <= cfg_wdata[11:0];
        REG_MAP_HEIGHT:  cfg_r.map_height_tiles  <= cfg_wdata[11:0];
        REG_VIEW_WIDTH:  cfg_r.view_width        <= cfg_wdata[9:0];
        REG_VIEW_HEIGHT: cfg_r.view_height       <= cfg_wdata[9:0];
        REG_BUF_HEIGHT:  cfg_r.buffer_height     <= cfg_wdata[10:0];
        REG_COL_RUN:     cfg_r.column_run_length <= cfg_wdata[4:0];
        REG_ROW_RUN:     cfg_r.row_run_length    <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  smtrs_front u_front (
    .cfg      (cfg_r),
    .camera_x (in_camera_x),
    .camera_y (in_camera_y),
    .delta_x  (in_delta_x),
    .delta_y  (in_delta_y),
    .frame    (front_frame)
  );

  smtrs_fifo #(
    .WIDTH ($bits(frame_t)),
    .DEPTH (FRAME_DEPTH)
  ) u_frame_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (front_frame),
    .full  (full),
    .pop   (fq_pop),
    .rdata (fq_data),
    .empty (fq_empty)
  );

  smtrs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .fq_empty (fq_empty),
    .fq_data  (fq_data),
    .fq_pop   (fq_pop),
    .oq_full  (oq_full),
    .oq_push  (oq_push),
    .oq_data  (oq_wdata)
  );

  smtrs_fifo #(
    .WIDTH ($bits(draw_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_wdata),
    .full  (oq_full),
    .pop   (pop),
    .rdata (oq_rdata),
    .empty (empty)
  );

  assign out_tile_x   = oq_rdata.tile_x;
  assign out_tile_y   = oq_rdata.tile_y;
  assign out_buffer_x = oq_rdata.buffer_x;
  assign out_buffer_y = oq_rdata.buffer_y;
  assign out_last     = oq_rdata.last;

endmodule

// ===== tb/sv/tb_scroll_margin_tile_redraw_scheduler_unit.sv =====
`timescale 1ns / 100ps

module tb_scroll_margin_tile_redraw_scheduler_unit;
  import smtrs_pkg::*;

  typedef enum logic [1:0] {
    PREDICTED,
    NO_DRAW,
    ONE_DRAW
  } check_kind_t;

  typedef struct packed {
    logic [15:0] cam_x;
    logic [15:0] cam_y;
    logic [15:0] delta_x;
    logic [15:0] delta_y;
    check_kind_t kind;
    draw_t       want;
  } opening_t;

  localparam draw_t NO_WANT = '0;
  localparam int OPENING_ROWS = 23;
  localparam int SETTLE_CYCLES = 64;

  // Right after reset (16-pixel tiles, 64 x 64 map, 320 x 256 view) the first
  // rows can be worked out by hand; the rest go through the predictor.
  localparam opening_t OPENING [OPENING_ROWS] = '{
    {16'd0, 16'd0, 16'h0000, 16'h0000, NO_DRAW, NO_WANT},
    {16'd0, 16'd0, 16'h0001, 16'h0000, ONE_DRAW, {12'd21, 12'd0, 16'd336, 10'd0, 1'b1}},
    {16'd0, 16'd0, 16'h8000, 16'h0000, NO_DRAW, NO_WANT},
    {16'd0, 16'd0, 16'h0000, 16'h0001, PREDICTED, NO_WANT},
    {16'd16, 16'd0, 16'h0001, 16'h0000, PREDICTED, NO_WANT},
    {16'd16, 16'd16, 16'h0001, 16'h0001, PREDICTED, NO_WANT},
    {16'd32, 16'd32, 16'h0001, 16'h0001, PREDICTED, NO_WANT},
    {16'd48, 16'd48, 16'h7FFF, 16'h7FFF, PREDICTED, NO_WANT},
    {16'd64, 16'd64, 16'h0000, 16'h0000, PREDICTED, NO_WANT},
    {16'd64, 16'd64, 16'h0000, 16'h0000, PREDICTED, NO_WANT},
    {16'd48, 16'd48, 16'hFFFF, 16'hFFFF, PREDICTED, NO_WANT},
    {16'd32, 16'd32, 16'hFFFF, 16'hFFFF, PREDICTED, NO_WANT},
    {16'd0, 16'd0, 16'hFFFF, 16'hFFFF, PREDICTED, NO_WANT},
    {16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001, PREDICTED, NO_WANT},
    {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, PREDICTED, NO_WANT},
    {16'd700, 16'd500, 16'h0001, 16'h0001, PREDICTED, NO_WANT},
    {16'd684, 16'd500, 16'h0001, 16'h0001, PREDICTED, NO_WANT},
    {16'd684, 16'd760, 16'h0001, 16'h0001, PREDICTED, NO_WANT},
    {16'd0, 16'hFFFF, 16'h0001, 16'hFFFF, PREDICTED, NO_WANT},
    {16'hFFFF, 16'd0, 16'hFFFF, 16'h0001, PREDICTED, NO_WANT},
    {16'd300, 16'd200, 16'hFFFB, 16'h0007, PREDICTED, NO_WANT},
    {16'd300, 16'd200, 16'h0000, 16'h0000, PREDICTED, NO_WANT},
    {16'd12345, 16'd54321, 16'h8000, 16'h7FFF, PREDICTED, NO_WANT}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = REG_TILE_SHIFT;
  logic [11:0]        cfg_wdata = 12'd0;
  logic               push = 1'b0;
  logic               full;
  logic [15:0]        in_camera_x = 16'd0;
  logic [15:0]        in_camera_y = 16'd0;
  logic signed [15:0] in_delta_x = 16'sd0;
  logic signed [15:0] in_delta_y = 16'sd0;
  logic               empty;
  logic               pop = 1'b0;
  logic [11:0]        out_tile_x;
  logic [11:0]        out_tile_y;
  logic [15:0]        out_buffer_x;
  logic [9:0]         out_buffer_y;
  logic               out_last;

  // Predictor copy of the registers and of both banks of margin state.
  cfg_t        regs;
  logic [15:0] lane_at [8];
  logic [15:0] lane_cursor [8];
  logic [15:0] lane_stop [8];
  logic        lead_fwd_x [2];
  logic        lead_fwd_y [2];
  logic        frame_bank;

  draw_t frame_draws [$];
  draw_t draws_due [$];
  draw_t got_draw;
  draw_t want_draw;

  int mismatches = 0;
  int planned_count = 0;
  int send_idle_pct = 35;
  int recv_idle_pct = 76;
  int walk_x;
  int walk_y;

  scroll_margin_tile_redraw_scheduler_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .push(push),
    .full(full),
    .in_camera_x(in_camera_x),
    .in_camera_y(in_camera_y),
    .in_delta_x(in_delta_x),
    .in_delta_y(in_delta_y),
    .empty(empty),
    .pop(pop),
    .out_tile_x(out_tile_x),
    .out_tile_y(out_tile_y),
    .out_buffer_x(out_buffer_x),
    .out_buffer_y(out_buffer_y),
    .out_last(out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic draw_t make_draw(input logic [15:0] tx, input logic [15:0] ty);
    draw_t       d;
    logic [31:0] wide_x;
    logic [31:0] wide_y;
    logic [31:0] wrap;
    wide_x = {16'd0, tx} << regs.tile_shift;
    wide_y = {16'd0, ty} << regs.tile_shift;
    // A buffer height of zero leaves every bit of the mask set.
    wrap = {21'd0, regs.buffer_height} - 32'd1;
    wide_y = wide_y & 32'h0000_FFFF & wrap;
    d.tile_x = tx[11:0];
    d.tile_y = ty[11:0];
    d.buffer_x = wide_x[15:0];
    d.buffer_y = wide_y[9:0];
    d.last = 1'b0;
    return d;
  endfunction

  task automatic add_draw(input logic is_y, input logic [15:0] pos, input logic [15:0] cur);
    if (is_y == AXIS_Y) begin
      frame_draws.push_back(make_draw(cur, pos));
    end else begin
      frame_draws.push_back(make_draw(pos, cur));
    end
  endtask

  task automatic plan_axis(input logic is_y, input int dir, input int unsigned lead_cam,
                           input int unsigned run_cam, input int unsigned view,
                           input int unsigned lead_lim, input int unsigned run_lim,
                           input int unsigned run_len);
    logic [1:0]  base;
    logic [2:0]  m;
    logic [2:0]  opp;
    int unsigned sh;
    int unsigned rlen;
    int          idx;
    int          sidx;
    int          c;
    int          e;
    logic [15:0] idx16;
    logic        fwd;
    sh = 32'(regs.tile_shift);
    rlen = (run_len > 32'(RUN_MAX)) ? 32'(RUN_MAX) : run_len;
    base = {frame_bank, is_y};
    fwd = (is_y == AXIS_Y) ? lead_fwd_y[frame_bank] : lead_fwd_x[frame_bank];
    if (dir != 0) begin
      if (dir > 0) begin
        idx = int'((lead_cam + view) >> sh) + 1;
        fwd = 1'b1;
      end else begin
        idx = int'(lead_cam >> sh) - 1;
        fwd = 1'b0;
      end
      if (is_y == AXIS_Y) begin
        lead_fwd_y[frame_bank] = fwd;
      end else begin
        lead_fwd_x[frame_bank] = fwd;
      end
      idx16 = idx[15:0];
      m = {base, ~fwd};
      opp = {base, fwd};
      if (idx16 != lane_at[m]) begin
        // The leading margin jumped: finish its old run in one go.
        while ($signed(lane_cursor[m]) < $signed(lane_stop[m])) begin
          add_draw(is_y, lane_at[m], lane_cursor[m]);
          lane_cursor[m] = lane_cursor[m] + 16'd1;
        end
        lane_at[m] = idx16;
        sidx = int'($signed(idx16));
        if (sidx < 0 || sidx >= int'(lead_lim)) begin
          lane_cursor[m] = 16'd0;
          lane_stop[m] = 16'd0;
        end else begin
          c = int'(run_cam >> sh) - int'(RUN_BACKOFF);
          if (c < 0) c = 0;
          e = c + int'(rlen);
          if (e > int'(run_lim)) e = int'(run_lim);
          lane_cursor[m] = c[15:0];
          lane_stop[m] = e[15:0];
        end
        lane_at[opp] = (dir > 0) ? lane_at[opp] + 16'd1 : lane_at[opp] - 16'd1;
        lane_cursor[opp] = 16'd0;
        lane_stop[opp] = 16'd0;
      end
    end
    m = {base, ~fwd};
    if ($signed(lane_cursor[m]) < $signed(lane_stop[m])) begin
      add_draw(is_y, lane_at[m], lane_cursor[m]);
      lane_cursor[m] = lane_cursor[m] + 16'd1;
    end
  endtask

  task automatic plan_frame(input logic [15:0] cx, input logic [15:0] cy,
                            input logic [15:0] dx, input logic [15:0] dy);
    frame_draws.delete();
    plan_axis(AXIS_X, int'($signed(dx)), 32'(cx), 32'(cy), 32'(regs.view_width),
              32'(regs.map_width_tiles), 32'(regs.map_height_tiles),
              32'(regs.column_run_length));
    plan_axis(AXIS_Y, int'($signed(dy)), 32'(cy), 32'(cx), 32'(regs.view_height),
              32'(regs.map_height_tiles), 32'(regs.map_width_tiles),
              32'(regs.row_run_length));
    frame_bank = ~frame_bank;
  endtask

  task automatic reset_plan();
    regs.tile_shift = 3'd4;
    regs.map_width_tiles = 12'd64;
    regs.map_height_tiles = 12'd64;
    regs.view_width = 10'd320;
    regs.view_height = 10'd256;
    regs.buffer_height = 11'd512;
    regs.column_run_length = 5'd20;
    regs.row_run_length = 5'd24;
    for (int i = 0; i < 8; i++) begin
      lane_at[i] = 16'd0;
      lane_cursor[i] = 16'd0;
      lane_stop[i] = 16'd0;
    end
    for (int i = 0; i < 2; i++) begin
      lead_fwd_x[i] = 1'b1;
      lead_fwd_y[i] = 1'b1;
    end
    frame_bank = 1'b0;
  endtask

  // Push stays high from one word to the next unless an idle cycle is drawn.
  task automatic send_frame(input logic [15:0] cx, input logic [15:0] cy,
                            input logic [15:0] dx, input logic [15:0] dy,
                            input check_kind_t kind, input draw_t want);
    draw_t d;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_camera_x <= cx;
    in_camera_y <= cy;
    in_delta_x <= dx;
    in_delta_y <= dy;
    @(posedge clk);
    while (full) @(posedge clk);
    plan_frame(cx, cy, dx, dy);
    if (kind == ONE_DRAW) begin
      draws_due.push_back(want);
      planned_count++;
    end else if (kind == PREDICTED) begin
      for (int i = 0; i < frame_draws.size(); i++) begin
        d = frame_draws[i];
        d.last = (i == frame_draws.size() - 1);
        draws_due.push_back(d);
        planned_count++;
      end
    end
  endtask

  task automatic drain_draws();
    push <= 1'b0;
    @(posedge clk);
    while (draws_due.size() != 0) @(posedge clk);
  endtask

  // Frames that draw nothing may still be in flight once the last draw is in.
  task automatic settle();
    drain_draws();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[11:0];
    @(posedge clk);
    case (idx)
      REG_TILE_SHIFT:  regs.tile_shift = value[2:0];
      REG_MAP_WIDTH:   regs.map_width_tiles = value[11:0];
      REG_MAP_HEIGHT:  regs.map_height_tiles = value[11:0];
      REG_VIEW_WIDTH:  regs.view_width = value[9:0];
      REG_VIEW_HEIGHT: regs.view_height = value[9:0];
      REG_BUF_HEIGHT:  regs.buffer_height = value[10:0];
      REG_COL_RUN:     regs.column_run_length = value[4:0];
      REG_ROW_RUN:     regs.row_run_length = value[4:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input int unsigned ts, input int unsigned mw, input int unsigned mh,
                           input int unsigned vw, input int unsigned vh, input int unsigned bh,
                           input int unsigned cr, input int unsigned rr);
    write_reg(REG_TILE_SHIFT, ts);
    write_reg(REG_MAP_WIDTH, mw);
    write_reg(REG_MAP_HEIGHT, mh);
    write_reg(REG_VIEW_WIDTH, vw);
    write_reg(REG_VIEW_HEIGHT, vh);
    write_reg(REG_BUF_HEIGHT, bh);
    write_reg(REG_COL_RUN, cr);
    write_reg(REG_ROW_RUN, rr);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input int phase);
    case (phase)
      0: write_all(1, 4095, 4095, 16, 16, 16, 29, 1);
      1: write_all(7, 4095, 1, 1023, 1023, 1024, 1, 29);
      // Single-pixel tiles, a buffer height that is not a power of two and
      // run lengths above the cap.
      2: write_all(0, 200, 150, 640, 480, 1000, 31, 30);
      3: write_all(2, 0, 4095, 0, 1023, 1024, 0, 17);
      4: write_all(5, 1000, 3000, 1023, 16, 0, 0, 31);
      default: write_all($urandom_range(1, 7), $urandom_range(1, 4095),
                         $urandom_range(1, 4095), $urandom_range(16, 1023),
                         $urandom_range(16, 1023), 1 << $urandom_range(4, 10),
                         $urandom_range(1, 29), $urandom_range(1, 29));
    endcase
  endtask

  function automatic int random_step(input int unsigned sh);
    int mag;
    if ($urandom_range(3) == 0) return 0;
    mag = $urandom_range(1, 2 << sh);
    return $urandom_range(1) ? mag : -mag;
  endfunction

  function automatic logic [15:0] motion_of(input int step);
    int v;
    if (step > 0) v = $urandom_range(1, 32767);
    else if (step < 0) v = -int'($urandom_range(1, 32768));
    else v = 0;
    return v[15:0];
  endfunction

  // Mostly a smooth camera walk through the map, so that runs get started,
  // drawn and flushed; now and then a word of pure noise.
  task automatic random_frame();
    int unsigned sh;
    int unsigned reach;
    int unsigned cap_x;
    int unsigned cap_y;
    int          step_x;
    int          step_y;
    sh = 32'(regs.tile_shift);
    // With single-pixel tiles a camera past the midpoint would start a run at a
    // negative tile and flush tens of thousands of draws; keep below it.
    reach = (sh == 0) ? 32767 : 65535;
    if ($urandom_range(99) < 15) begin
      send_frame(16'($urandom_range(reach)), 16'($urandom_range(reach)),
                 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                 PREDICTED, NO_WANT);
    end else begin
      cap_x = 32'(regs.map_width_tiles);
      cap_x = cap_x << sh;
      if (cap_x > reach) cap_x = reach;
      cap_y = 32'(regs.map_height_tiles);
      cap_y = cap_y << sh;
      if (cap_y > reach) cap_y = reach;
      step_x = random_step(sh);
      step_y = random_step(sh);
      walk_x = walk_x + step_x;
      walk_y = walk_y + step_y;
      if (walk_x < 0) walk_x = 0;
      if (walk_x > int'(cap_x)) walk_x = cap_x;
      if (walk_y < 0) walk_y = 0;
      if (walk_y > int'(cap_y)) walk_y = cap_y;
      send_frame(walk_x[15:0], walk_y[15:0], motion_of(step_x), motion_of(step_y),
                 PREDICTED, NO_WANT);
    end
  endtask

  task automatic run_random(input int count, input logic hold_midway);
    int sent;
    int first;
    sent = 0;
    first = planned_count;
    while (sent < count || (planned_count - first < 12 && sent < 2 * count)) begin
      if (hold_midway && sent == count / 2) drain_draws();
      random_frame();
      sent++;
    end
  endtask

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Each popped word is matched against the oldest outstanding draw.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      got_draw = {out_tile_x, out_tile_y, out_buffer_x, out_buffer_y, out_last};
      if (draws_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected draw: tile %0d,%0d buffer %0d,%0d last %0d",
                   got_draw.tile_x, got_draw.tile_y, got_draw.buffer_x,
                   got_draw.buffer_y, got_draw.last);
        end
      end else begin
        want_draw = draws_due.pop_front();
        if (got_draw !== want_draw) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("draw differs: expected tile %0d,%0d buffer %0d,%0d last %0d",
                     want_draw.tile_x, want_draw.tile_y, want_draw.buffer_x,
                     want_draw.buffer_y, want_draw.last);
            $display("              got      tile %0d,%0d buffer %0d,%0d last %0d",
                     got_draw.tile_x, got_draw.tile_y, got_draw.buffer_x,
                     got_draw.buffer_y, got_draw.last);
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("scroll_margin_tile_redraw_scheduler_unit: mismatch");
    $finish;
  end

  initial begin
    reset_plan();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < OPENING_ROWS; i++) begin
      send_frame(OPENING[i].cam_x, OPENING[i].cam_y, OPENING[i].delta_x,
                 OPENING[i].delta_y, OPENING[i].kind, OPENING[i].want);
    end

    for (int p = 0; p < 6; p++) begin
      settle();
      send_idle_pct = (p < 2) ? 35 : (p < 4) ? 76 : 0;
      recv_idle_pct = (p < 2) ? 76 : (p < 4) ? 35 : 0;
      apply_setting(p);
      walk_x = 0;
      walk_y = 0;
      run_random((p == 3) ? 10 : 25, p == 1);
    end

    settle();
    if (mismatches == 0) begin
      $display("scroll_margin_tile_redraw_scheduler_unit: match");
    end else begin
      $display("scroll_margin_tile_redraw_scheduler_unit: mismatch");
    end
    $finish;
  end

endmodule
